[rtl/core/rmq_pkg.sv]
// Shared constants, width helpers and sideband types of the matrix-to-quaternion core.
`timescale 1ns / 1ps

package rmq_pkg;

  // Default fraction width of all fixed-point values.
  localparam int FRAC_BITS_DEF = 14;

  // Widths of one matrix entry and of the result fields.
  localparam int M_W  = 16;
  localparam int Q_W  = 16;
  localparam int QW_W = 15;

  // Largest value a 16-bit signed result can carry.
  localparam int FIELD_MAX = 32767;

  // Root bits resolved in each square-root pipeline stage.
  localparam int STEP_BITS = 2;

  // Four trace combinations are rooted side by side.
  localparam int LANES  = 4;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int LANE_W = 3;

  localparam int IN_W  = 9 * M_W;
  localparam int OUT_W = 64;

  // Unsigned width of a positive trace combination: 2^f plus three entries.
  function automatic int trace_w(input int f);
    trace_w = ((f > 17) ? f : 17) + 1;
  endfunction

  // Root width, padded up to a whole number of pipeline stages.
  function automatic int root_w(input int f);
    int rw;
    int rb;
    int ns;
    rw = trace_w(f) + f;
    rb = (rw + 1) / 2;
    ns = (rb + STEP_BITS - 1) / STEP_BITS;
    root_w = ns * STEP_BITS;
  endfunction

  function automatic int num_stages(input int f);
    num_stages = root_w(f) / STEP_BITS;
  endfunction

  // Saturation limit of a magnitude: 1.0 or the largest 16-bit value.
  function automatic int q_limit(input int f);
    q_limit = (f < 15) ? (1 << f) : FIELD_MAX;
  endfunction

  // Sign flags of the vector part, taken from the off-diagonal differences.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } sign_t;

endpackage

[rtl/core/rmq_front.sv]
// Input stage: forms the four clamped trace combinations and the sign flags.
`timescale 1ns / 1ps

module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic [rmq_pkg::IN_W-1:0]                                in_data,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output logic [rmq_pkg::LANES-1:0][2*rmq_pkg::root_w(FRAC_BITS)-1:0] out_rad,
  output rmq_pkg::sign_t                                          out_sign
);

  localparam int TW  = rmq_pkg::trace_w(FRAC_BITS);
  localparam int TSW = TW + 1;
  localparam int RWP = 2 * rmq_pkg::root_w(FRAC_BITS);
  localparam int MW  = rmq_pkg::M_W;

  logic signed [TSW-1:0] one_s;
  logic signed [TSW-1:0] e11, e22, e33;
  logic signed [TSW-1:0] t_w, t_x, t_y, t_z;
  logic [rmq_pkg::LANES-1:0][RWP-1:0] rad_next;
  logic [MW:0] dx, dy, dz;
  rmq_pkg::sign_t sign_next;

  logic [MW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;

  assign m11 = in_data[0*MW +: MW];
  assign m12 = in_data[1*MW +: MW];
  assign m13 = in_data[2*MW +: MW];
  assign m21 = in_data[3*MW +: MW];
  assign m22 = in_data[4*MW +: MW];
  assign m23 = in_data[5*MW +: MW];
  assign m31 = in_data[6*MW +: MW];
  assign m32 = in_data[7*MW +: MW];
  assign m33 = in_data[8*MW +: MW];

  assign one_s = TSW'(1) << FRAC_BITS;
  assign e11 = {{(TSW-MW){m11[MW-1]}}, m11};
  assign e22 = {{(TSW-MW){m22[MW-1]}}, m22};
  assign e33 = {{(TSW-MW){m33[MW-1]}}, m33};

  assign t_w = one_s + e11 + e22 + e33;
  assign t_x = one_s + e11 - e22 - e33;
  assign t_y = one_s - e11 + e22 - e33;
  assign t_z = one_s - e11 - e22 + e33;

  // A non-positive combination roots to zero.
  function automatic logic [RWP-1:0] to_rad(input logic signed [TSW-1:0] t);
    logic [RWP-1:0] r;
    if (t[TSW-1] || (t == '0)) begin
      r = '0;
    end else begin
      r = {{(RWP-TW){1'b0}}, t[TW-1:0]} << FRAC_BITS;
    end
    return r;
  endfunction

  assign rad_next[rmq_pkg::LANE_X] = to_rad(t_x);
  assign rad_next[rmq_pkg::LANE_Y] = to_rad(t_y);
  assign rad_next[rmq_pkg::LANE_Z] = to_rad(t_z);
  assign rad_next[rmq_pkg::LANE_W] = to_rad(t_w);

  assign dx = {m32[MW-1], m32} - {m23[MW-1], m23};
  assign dy = {m13[MW-1], m13} - {m31[MW-1], m31};
  assign dz = {m21[MW-1], m21} - {m12[MW-1], m12};

  assign sign_next.neg_x = dx[MW];
  assign sign_next.neg_y = dy[MW];
  assign sign_next.neg_z = dz[MW];

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rad  <= rad_next;
      out_sign <= sign_next;
    end
  end

endmodule

[rtl/core/rmq_root_stage.sv]
// One square-root pipeline stage: resolves a few root bits in all four lanes.
`timescale 1ns / 1ps

module rmq_root_stage #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                                      clk,
  input  logic                                                      rst,
  input  logic                                                      in_valid,
  output logic                                                      in_ready,
  input  logic [rmq_pkg::LANES-1:0][2*rmq_pkg::root_w(FRAC_BITS)-1:0] in_rad,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::root_w(FRAC_BITS)+1:0]   in_rem,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::root_w(FRAC_BITS)-1:0]   in_root,
  input  rmq_pkg::sign_t                                            in_sign,
  output logic                                                      out_valid,
  input  logic                                                      out_ready,
  output logic [rmq_pkg::LANES-1:0][2*rmq_pkg::root_w(FRAC_BITS)-1:0] out_rad,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::root_w(FRAC_BITS)+1:0]   out_rem,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::root_w(FRAC_BITS)-1:0]   out_root,
  output rmq_pkg::sign_t                                            out_sign
);

  localparam int RBP = rmq_pkg::root_w(FRAC_BITS);
  localparam int RWP = 2 * RBP;

  logic [rmq_pkg::LANES-1:0][RWP-1:0] rad_next;
  logic [rmq_pkg::LANES-1:0][RBP+1:0] rem_next;
  logic [rmq_pkg::LANES-1:0][RBP-1:0] root_next;

  // Restoring digit recurrence: bring down two radicand bits, try 4*root+1.
  always_comb begin
    logic [RWP-1:0] rad;
    logic [RBP+1:0] rem;
    logic [RBP-1:0] root;
    logic [RBP+3:0] cand;
    logic [RBP+3:0] trial;
    logic [RBP+3:0] diff;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      rad  = in_rad[l];
      rem  = in_rem[l];
      root = in_root[l];
      for (int k = 0; k < rmq_pkg::STEP_BITS; k++) begin
        cand  = {rem, rad[RWP-1 -: 2]};
        trial = {2'b00, root, 2'b01};
        diff  = cand - trial;
        if (cand >= trial) begin
          rem  = diff[RBP+1:0];
          root = {root[RBP-2:0], 1'b1};
        end else begin
          rem  = cand[RBP+1:0];
          root = {root[RBP-2:0], 1'b0};
        end
        rad = rad << 2;
      end
      rad_next[l]  = rad;
      rem_next[l]  = rem;
      root_next[l] = root;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rad  <= rad_next;
      out_rem  <= rem_next;
      out_root <= root_next;
      out_sign <= in_sign;
    end
  end

endmodule

[rtl/core/rmq_out.sv]
// Output stage: halves and saturates each root, applies signs, holds the result beat.
`timescale 1ns / 1ps

module rmq_out #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::root_w(FRAC_BITS)-1:0] in_root,
  input  rmq_pkg::sign_t                                          in_sign,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output logic [rmq_pkg::OUT_W-1:0]                               out_data
);

  localparam int RBP = rmq_pkg::root_w(FRAC_BITS);
  localparam int CW  = RBP + 16;
  localparam int QW  = rmq_pkg::Q_W;
  localparam logic [QW-1:0] LIM = QW'(rmq_pkg::q_limit(FRAC_BITS));

  logic [rmq_pkg::LANES-1:0][QW-1:0] mag;
  logic [QW-1:0] qx, qy, qz;
  logic [rmq_pkg::OUT_W-1:0] data_next;

  always_comb begin
    logic [CW-1:0] magx;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      magx = {17'd0, in_root[l][RBP-1:1]};
      mag[l] = (magx > {{(CW-QW){1'b0}}, LIM}) ? LIM : magx[QW-1:0];
    end
  end

  assign qx = in_sign.neg_x ? (~mag[rmq_pkg::LANE_X] + QW'(1)) : mag[rmq_pkg::LANE_X];
  assign qy = in_sign.neg_y ? (~mag[rmq_pkg::LANE_Y] + QW'(1)) : mag[rmq_pkg::LANE_Y];
  assign qz = in_sign.neg_z ? (~mag[rmq_pkg::LANE_Z] + QW'(1)) : mag[rmq_pkg::LANE_Z];

  assign data_next = {1'b0, mag[rmq_pkg::LANE_W][rmq_pkg::QW_W-1:0], qz, qy, qx};

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/core/rotation_matrix_to_quaternion_core.sv]
// Top level of the rotation-matrix-to-quaternion core.
// Throughput: one beat per clock unless m_tready stalls; depth from root stages, 2 bits each.
// Reset: rst is synchronous and active high; it empties every pipeline stage.
// There is no configuration and no state beyond the beats in flight.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Input matrix beat.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // s_tdata, low bit up: m11, m12, m13, m21, m22, m23, m31, m32, m33 (16 bits each).
  input  logic [rmq_pkg::IN_W-1:0]   s_tdata,
  // Result quaternion beat.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m_tdata, low bit up: qx (16), qy (16), qz (16), qw (15), one zero pad bit.
  output logic [rmq_pkg::OUT_W-1:0]  m_tdata
);

  // The pipeline is a front stage (trace sums, clamp, sign flags), a chain of
  // square-root stages that each resolve two root bits in all four lanes, and an
  // output stage that halves, saturates and signs the roots. Every stage has its
  // own valid bit and is ready when empty or when its successor moves, so bubbles
  // are squeezed out and a stall at the output backs up without losing a beat.

  localparam int RBP = rmq_pkg::root_w(FRAC_BITS);
  localparam int RWP = 2 * RBP;
  localparam int NS  = rmq_pkg::num_stages(FRAC_BITS);
  localparam int LN  = rmq_pkg::LANES;
  localparam int QW  = rmq_pkg::Q_W;
  localparam logic signed [QW:0] LIM_S = (QW+1)'(rmq_pkg::q_limit(FRAC_BITS));

  logic                        vld  [NS+1];
  logic                        rdy  [NS+1];
  logic [LN-1:0][RWP-1:0]      rad  [NS+1];
  logic [LN-1:0][RBP+1:0]      rem  [NS+1];
  logic [LN-1:0][RBP-1:0]      root [NS+1];
  rmq_pkg::sign_t              sgn  [NS+1];

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_rad   (rad[0]),
    .out_sign  (sgn[0])
  );

  // The recurrence starts from a zero remainder and a zero root.
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_root
    rmq_root_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_rad    (rad[i]),
      .in_rem    (rem[i]),
      .in_root   (root[i]),
      .in_sign   (sgn[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_rad   (rad[i+1]),
      .out_rem   (rem[i+1]),
      .out_root  (root[i+1]),
      .out_sign  (sgn[i+1])
    );
  end

  // The remainder and leftover radicand of the last stage are no longer needed.
  rmq_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[NS]),
    .in_ready  (rdy[NS]),
    .in_root   (root[NS]),
    .in_sign   (sgn[NS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  // Back-pressure only ever starts at a held result beat.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a held result beat");

  // The scalar part never exceeds the saturation limit.
  a_qw_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({2'b00, m_tdata[62:48]} <= LIM_S))
    else $error("qw above saturation limit");

  // The x vector component stays within plus or minus the limit.
  a_qx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (($signed({m_tdata[15], m_tdata[15:0]}) <= LIM_S) &&
                  ($signed({m_tdata[15], m_tdata[15:0]}) >= -LIM_S)))
    else $error("qx outside saturation range");

  // The pad bit of the result beat is always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63] == 1'b0))
    else $error("result pad bit set");

endmodule

[tb/tb_rotation_matrix_to_quaternion_core.sv]
// Self-checking testbench for the rotation-matrix-to-quaternion core.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_core;

  localparam int FRAC = rmq_pkg::FRAC_BITS_DEF;
  localparam longint unsigned MAG_LIMIT = (FRAC < 15) ? (64'd1 << FRAC) : 64'd32767;
  localparam int RAND_ITEMS = 1200;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;
  localparam int N_DIR = 16;

  // Nine entries, m11 at index 0 up to m33 at index 8; index 0 lands in the low bits.
  typedef logic [8:0][rmq_pkg::M_W-1:0] mat_t;

  // Same layout as m_tdata, so a result beat can be cast straight into it.
  typedef struct packed {
    logic                     pad;
    logic [rmq_pkg::QW_W-1:0] qw;
    logic [rmq_pkg::Q_W-1:0]  qz;
    logic [rmq_pkg::Q_W-1:0]  qy;
    logic [rmq_pkg::Q_W-1:0]  qx;
  } quat_t;

  typedef struct packed {
    mat_t  mat;
    logic  typed;
    quat_t want;
  } dir_row_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [rmq_pkg::IN_W-1:0]  s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [rmq_pkg::OUT_W-1:0] m_tdata;

  quat_t pending_quats[$];
  int    fail_count;
  int    beats_sent;
  int    beats_checked;
  int    n_rotation;
  int    n_raw;
  int    n_box;
  int    cycles;
  int    longest_hold;

  rotation_matrix_to_quaternion_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
  end

  always #6 clk = ~clk;

  // Build a matrix from entries given row by row.
  function automatic mat_t mk(input int a11, input int a12, input int a13,
                              input int a21, input int a22, input int a23,
                              input int a31, input int a32, input int a33);
    mat_t r;
    r = {a33[15:0], a32[15:0], a31[15:0], a23[15:0], a22[15:0],
         a21[15:0], a13[15:0], a12[15:0], a11[15:0]};
    return r;
  endfunction

  // Integer square root by setting result bits from the top down.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Half the root of one trace combination, with negatives clamped and large values capped.
  function automatic longint unsigned half_root_mag(input longint t);
    longint unsigned m;
    if (t <= 0) return 0;
    m = root_floor(longint'(unsigned'(t)) << FRAC) >> 1;
    return (m > MAG_LIMIT) ? MAG_LIMIT : m;
  endfunction

  // A zero difference leaves the component positive.
  function automatic logic [rmq_pkg::Q_W-1:0] signed_comp(input longint unsigned mag,
                                                          input longint diff);
    logic [rmq_pkg::Q_W-1:0] v;
    v = mag[rmq_pkg::Q_W-1:0];
    if (diff < 0) v = -v;
    return v;
  endfunction

  function automatic quat_t predict_quat(input mat_t mx);
    longint e [9];
    longint one;
    quat_t q;
    for (int i = 0; i < 9; i++) e[i] = $signed(mx[i]);
    one = longint'(1) << FRAC;
    q.pad = 1'b0;
    q.qx = signed_comp(half_root_mag(one + e[0] - e[4] - e[8]), e[7] - e[5]);
    q.qy = signed_comp(half_root_mag(one - e[0] + e[4] - e[8]), e[2] - e[6]);
    q.qz = signed_comp(half_root_mag(one - e[0] - e[4] + e[8]), e[3] - e[1]);
    q.qw = rmq_pkg::QW_W'(half_root_mag(one + e[0] + e[4] + e[8]));
    return q;
  endfunction

  // A proper rotation built from a random quaternion, with now and then one
  // vector component forced to zero so that its sign difference is zero before entry noise.
  function automatic mat_t random_rotation();
    real a, b, c, d, n;
    real r [9];
    mat_t mx;
    int noise;
    a = real'($urandom_range(0, 2000)) - 1000.0;
    b = real'($urandom_range(0, 2000)) - 1000.0;
    c = real'($urandom_range(0, 2000)) - 1000.0;
    d = real'($urandom_range(0, 2000)) + 1.0;
    case ($urandom_range(0, 9))
      0: a = 0.0;
      1: b = 0.0;
      2: c = 0.0;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 0) d = -d;
    n = $sqrt(a * a + b * b + c * c + d * d);
    a = a / n;
    b = b / n;
    c = c / n;
    d = d / n;
    r[0] = 1.0 - 2.0 * (b * b + c * c);
    r[1] = 2.0 * (a * b - c * d);
    r[2] = 2.0 * (a * c + b * d);
    r[3] = 2.0 * (a * b + c * d);
    r[4] = 1.0 - 2.0 * (a * a + c * c);
    r[5] = 2.0 * (b * c - a * d);
    r[6] = 2.0 * (a * c - b * d);
    r[7] = 2.0 * (b * c + a * d);
    r[8] = 1.0 - 2.0 * (a * a + b * b);
    for (int i = 0; i < 9; i++) begin
      noise = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8)) - 4 : 0;
      mx[i] = 16'($rtoi(r[i] * 16384.0 + ((r[i] >= 0.0) ? 0.5 : -0.5)) + noise);
    end
    return mx;
  endfunction

  // Offer one matrix and hold it until the block takes it. Valid stays high on
  // return, so back-to-back beats never see a low pulse.
  task automatic push_matrix(input mat_t mx, input quat_t want);
    s_tdata <= mx;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_quats.push_back(want);
    beats_sent++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: every accepted beat is matched against the oldest prediction.
  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_quats.size() == 0) begin
        $error("result beat with no matrix outstanding: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_quats.pop_front();
        check_field("qx", $signed(want.qx), $signed(got.qx));
        check_field("qy", $signed(want.qy), $signed(got.qy));
        check_field("qz", $signed(want.qz), $signed(got.qz));
        check_field("qw", want.qw, got.qw);
        check_field("pad", want.pad, got.pad);
        beats_checked++;
      end
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_quats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: its own mix of stall patterns, plus one long hold-off once the
  // random traffic is underway, so the pipeline fills and pushes back.
  initial begin
    int mode;
    int left;
    bit held;
    held = 1'b0;
    mode = 0;
    left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && beats_sent >= 400) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        longest_hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 0);
        2: m_tready <= ($urandom_range(0, 9) != 0);
        default: m_tready <= (cycles % 3 == 0);
      endcase
    end
  end

  // Stimulus: directed rows first, then random traffic in bursts.
  initial begin
    dir_row_t dir_rows [N_DIR];
    mat_t mx;
    int burst_left;
    int gap;
    int pick;

    beats_sent = 0;
    n_rotation = 0;
    n_raw = 0;
    n_box = 0;

    // Rows whose quaternion is obvious carry it; the rest go through the predictor.
    // Identity: only w survives, at exactly 1.0.
    dir_rows[0] = '{mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1,
                    '{pad: 1'b0, qw: 15'd16384, qz: 16'd0, qy: 16'd0, qx: 16'd0}};
    // All-zero matrix: every combination is 1.0, so all four are one half, all positive.
    dir_rows[1] = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                    '{pad: 1'b0, qw: 15'd8192, qz: 16'd8192, qy: 16'd8192, qx: 16'd8192}};
    // Half turn about x with a zero difference: x stays positive.
    dir_rows[2] = '{mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b1,
                    '{pad: 1'b0, qw: 15'd0, qz: 16'd0, qy: 16'd0, qx: 16'd16384}};
    // Half turn about y with a negative m13 - m31.
    dir_rows[3] = '{mk(-16384, 0, -3, 0, 16384, 0, 3, 0, -16384), 1'b1,
                    '{pad: 1'b0, qw: 15'd0, qz: 16'd0, qy: -16'sd16384, qx: 16'd0}};
    // Half turn about z with a negative m21 - m12.
    dir_rows[4] = '{mk(-16384, 1, 0, -1, -16384, 0, 0, 0, 16384), 1'b1,
                    '{pad: 1'b0, qw: 15'd0, qz: -16'sd16384, qy: 16'd0, qx: 16'd0}};
    // Non-rotation input: x saturates at 1.0 and then takes its negative sign.
    dir_rows[5] = '{mk(32767, 0, 0, 0, -32768, 5, 0, -5, -32768), 1'b1,
                    '{pad: 1'b0, qw: 15'd0, qz: 16'd0, qy: 16'd0, qx: -16'sd16384}};
    dir_rows[6] = '{mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                       -32768), 1'b0, '0};
    dir_rows[7] = '{mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                    1'b0, '0};
    dir_rows[8] = '{mk(-16384, 16384, -16384, 16384, -16384, 16384, -16384, 16384,
                       -16384), 1'b0, '0};
    // Quarter turn about z.
    dir_rows[9] = '{mk(0, -16384, 0, 16384, 0, 0, 0, 0, 16384), 1'b0, '0};
    // Symmetric off-diagonals: every sign difference is zero.
    dir_rows[10] = '{mk(1000, 5000, -7000, 5000, 2000, 9000, -7000, 9000, -3000), 1'b0, '0};
    // Only the w combination is negative and clamped; x, y and z each see 2.0.
    dir_rows[11] = '{mk(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0, '0};
    dir_rows[12] = '{mk(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                        16'h5555, 16'haaaa, 16'h5555), 1'b0, '0};
    // Differences wider than 16 bits, positive and negative.
    dir_rows[13] = '{mk(30000, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768),
                     1'b0, '0};
    dir_rows[14] = '{mk(-32768, 32767, -32768, -32768, 30000, 32767, 32767, -32768, -32768),
                     1'b0, '0};
    dir_rows[15] = '{mk(-32768, 1, -1, -1, -32768, 1, 1, -1, 32767), 1'b0, '0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      push_matrix(dir_rows[i].mat,
                  dir_rows[i].typed ? dir_rows[i].want : predict_quat(dir_rows[i].mat));
    end

    // Mostly genuine rotations; the rest are raw bit patterns and matrices
    // filled at random inside the nominal range.
    burst_left = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        mx = random_rotation();
        n_rotation++;
      end else if (pick < 85) begin
        for (int k = 0; k < 9; k++) mx[k] = 16'($urandom());
        n_raw++;
      end else begin
        for (int k = 0; k < 9; k++) mx[k] = 16'(int'($urandom_range(0, 32768)) - 16384);
        n_box++;
      end
      push_matrix(mx, predict_quat(mx));
    end
    s_tvalid <= 1'b0;

    while (pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d quaternions from %0d directed, %0d rotation, %0d raw and %0d boxed",
             beats_checked, N_DIR, n_rotation, n_raw, n_box);
    $display("matrices in %0d cycles, with one %0d-cycle output hold-off.",
             cycles, longest_hold);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
